@@ hdl/lqjg_pkg.sv @@
// Shared types, codes and constants of the link quality jitter grader.
// No dependencies; every other file of the block imports this package.
package lqjg_pkg;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_EVENT  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam logic [2:0] SESS_IDLE       = 3'd0;
    localparam logic [2:0] SESS_CONNECTING = 3'd1;
    localparam logic [2:0] SESS_STREAMING  = 3'd2;
    localparam logic [2:0] SESS_BACKOFF    = 3'd3;
    localparam logic [2:0] SESS_RECONNECT  = 3'd4;
    localparam logic [2:0] SESS_ERROR      = 3'd5;
    localparam logic [2:0] SESS_STOPPED    = 3'd6;

    localparam logic [1:0] LEVEL_GOOD = 2'd0;
    localparam logic [1:0] LEVEL_FAIR = 2'd1;
    localparam logic [1:0] LEVEL_POOR = 2'd2;
    localparam logic [1:0] LEVEL_BAD  = 2'd3;

    localparam logic [15:0] VD_BAD   = 16'd1000;
    localparam logic [15:0] WB_BAD   = 16'd500;
    localparam logic [15:0] RTT_BAD  = 16'd500;
    localparam logic [15:0] VD_POOR  = 16'd400;
    localparam logic [15:0] WB_POOR  = 16'd150;
    localparam logic [15:0] RTT_POOR = 16'd200;
    localparam logic [15:0] JIT_POOR = 16'd80;
    localparam logic [15:0] VD_FAIR  = 16'd150;
    localparam logic [15:0] WB_FAIR  = 16'd50;
    localparam logic [15:0] RTT_FAIR = 16'd120;
    localparam logic [15:0] JIT_FAIR = 16'd40;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // One classified item as it travels from the front end to the executor.
    typedef struct packed {
        t_cmd        cmd;
        logic        has_rtt;
        logic [15:0] rtt;
        logic [15:0] video_delay;
        logic [15:0] write_block;
        logic [2:0]  session;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [3:0] {
        EX_IDLE,
        EX_SQUARE_OLD,
        EX_ACCUM,
        EX_MUL_SQ,
        EX_MUL_SUM,
        EX_SPREAD,
        EX_SQRT,
        EX_DIV,
        EX_OUT
    } t_ex_state;

    function automatic logic [1:0] grade_level(
        input logic [2:0]  session,
        input logic [15:0] vd,
        input logic [15:0] wb,
        input logic [15:0] rtt,
        input logic [15:0] jit
    );
        logic [1:0] level;
        if (session == SESS_IDLE || session == SESS_ERROR || session == SESS_STOPPED) begin
            level = LEVEL_BAD;
        end else if (vd >= VD_BAD || wb >= WB_BAD || rtt >= RTT_BAD) begin
            level = LEVEL_BAD;
        end else if (vd >= VD_POOR || wb >= WB_POOR || rtt >= RTT_POOR
                     || jit >= JIT_POOR) begin
            level = LEVEL_POOR;
        end else if (vd >= VD_FAIR || wb >= WB_FAIR || rtt >= RTT_FAIR
                     || jit >= JIT_FAIR) begin
            level = LEVEL_FAIR;
        end else begin
            level = LEVEL_GOOD;
        end
        return level;
    endfunction

endpackage

@@ hdl/lqjg_front.sv @@
// Front end: registers an incoming item and classifies its command.
// Depends on lqjg_pkg.
module lqjg_front
    import lqjg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_rtt_ms,
    input  logic [15:0] i_video_delay_ms,
    input  logic [15:0] i_write_block_ms,
    input  logic [2:0]  i_session_state,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_q_full
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_push     = r_valid && !i_q_full;
    assign o_in_ready = !r_valid || !i_q_full;
    assign o_item     = r_item;

    always_comb begin
        n_item.cmd         = t_cmd'(i_command);
        n_item.has_rtt     = (i_rtt_ms != 16'd0);
        n_item.rtt         = i_rtt_ms;
        n_item.video_delay = i_video_delay_ms;
        n_item.write_block = i_write_block_ms;
        n_item.session     = i_session_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= n_item;
        end
    end

endmodule

@@ hdl/lqjg_queue.sv @@
// Two-entry queue between the front end and the executor.
// Depends on lqjg_pkg.
module lqjg_queue
    import lqjg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_stat
);

    t_item      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_item       = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ hdl/lqjg_back.sv @@
// Executor: keeps the rtt window and session statistics, computes the jitter
// with a bit-serial square root and divide, and holds the result register.
// Depends on lqjg_pkg.
module lqjg_back
    import lqjg_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_q_empty,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_network_level,
    output logic [15:0] o_jitter_ms,
    output logic [15:0] o_reconnect_count
);

    localparam int HW       = $clog2(WINDOW);
    localparam int NW       = $clog2(WINDOW + 1);
    localparam int SUM_W    = 16 + HW;
    localparam int SQ_W     = 32 + HW;
    localparam int SPREAD_W = SQ_W + NW;
    localparam int ROOT_W   = (SPREAD_W + 1) / 2;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int CW       = $clog2(ROOT_W + 1);

    t_ex_state r_state;
    t_ex_state n_state;

    logic [15:0]       r_window [WINDOW];
    logic [NW-1:0]     r_fill;
    logic [HW-1:0]     r_head;
    logic [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]   r_sq_sum;
    logic [15:0]       r_last_rtt;
    logic [15:0]       r_last_vd;
    logic [15:0]       r_last_wb;
    logic [2:0]        r_session;
    logic [15:0]       r_jitter;
    logic              r_streamed;
    logic              r_pending;
    logic [15:0]       r_reconnects;

    logic [15:0]       r_new_rtt;
    logic [15:0]       r_old_rtt;
    logic [31:0]       r_new_sq;
    logic [31:0]       r_old_sq;
    logic [RAD_W-1:0]  r_prod_a;
    logic [RAD_W-1:0]  r_prod_b;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_srem;
    logic [ROOT_W-1:0] r_root;
    logic [NW-1:0]     r_drem;
    logic [CW-1:0]     r_cnt;

    logic              r_out_valid;
    logic [1:0]        r_out_level;
    logic [15:0]       r_out_jitter;
    logic [15:0]       r_out_count;

    logic                 out_load;
    logic                 full;
    logic                 last_step;
    logic [HW-1:0]        head_nx;
    logic [SPREAD_W-1:0]  prod_fill_sq;
    logic [2*SUM_W-1:0]   prod_sum_sum;
    logic [ROOT_W+1:0]    rem_sh;
    logic [ROOT_W+1:0]    trial;
    logic                 sq_bit;
    logic [ROOT_W-1:0]    srem_nx;
    logic [ROOT_W-1:0]    root_nx;
    logic [NW:0]          div_t;
    logic                 div_bit;
    logic [NW-1:0]        drem_nx;
    logic [ROOT_W-1:0]    quot_nx;

    assign full      = (r_fill == NW'(WINDOW));
    assign last_step = (r_cnt == CW'(1));
    assign head_nx   = (r_head == HW'(WINDOW - 1)) ? '0 : r_head + HW'(1);

    assign prod_fill_sq = SPREAD_W'(r_sq_sum) * SPREAD_W'(r_fill);
    assign prod_sum_sum = (2 * SUM_W)'(r_sum) * (2 * SUM_W)'(r_sum);

    // One result bit of the square root per cycle, radicand consumed two bits at a time.
    assign rem_sh  = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign trial   = {r_root, 2'b01};
    assign sq_bit  = (rem_sh >= trial);
    assign srem_nx = sq_bit ? ROOT_W'(rem_sh - trial) : ROOT_W'(rem_sh);
    assign root_nx = {r_root[ROOT_W-2:0], sq_bit};

    // Restoring divide of the root by the fill count, one quotient bit per cycle.
    assign div_t   = {r_drem, r_root[ROOT_W-1]};
    assign div_bit = (div_t >= {1'b0, r_fill});
    assign drem_nx = div_bit ? NW'(div_t - {1'b0, r_fill}) : NW'(div_t);
    assign quot_nx = {r_root[ROOT_W-2:0], div_bit};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EX_IDLE: begin
                if (!i_q_empty) begin
                    if (i_item.cmd == CMD_SAMPLE && i_item.has_rtt) begin
                        n_state = EX_SQUARE_OLD;
                    end else if (i_item.cmd == CMD_SAMPLE) begin
                        n_state = EX_MUL_SQ;
                    end else begin
                        n_state = EX_OUT;
                    end
                end
            end
            EX_SQUARE_OLD: n_state = EX_ACCUM;
            EX_ACCUM:      n_state = EX_MUL_SQ;
            EX_MUL_SQ:     n_state = (r_fill < NW'(2)) ? EX_OUT : EX_MUL_SUM;
            EX_MUL_SUM:    n_state = EX_SPREAD;
            EX_SPREAD:     n_state = EX_SQRT;
            EX_SQRT:       n_state = last_step ? EX_DIV : EX_SQRT;
            EX_DIV:        n_state = last_step ? EX_OUT : EX_DIV;
            EX_OUT:        n_state = out_load ? EX_IDLE : EX_OUT;
            default:       n_state = EX_IDLE;
        endcase
    end

    // Handshake strobes.
    always_comb begin
        o_pop    = (r_state == EX_IDLE) && !i_q_empty;
        out_load = (r_state == EX_OUT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EX_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Statistics that have reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_head       <= '0;
            r_sum        <= '0;
            r_sq_sum     <= '0;
            r_last_rtt   <= '0;
            r_last_vd    <= '0;
            r_last_wb    <= '0;
            r_session    <= SESS_IDLE;
            r_jitter     <= '0;
            r_streamed   <= 1'b0;
            r_pending    <= 1'b0;
            r_reconnects <= '0;
        end else begin
            unique case (r_state)
                EX_IDLE: begin
                    if (o_pop) begin
                        unique case (i_item.cmd)
                            CMD_SAMPLE: begin
                                r_last_rtt <= i_item.rtt;
                                r_last_vd  <= i_item.video_delay;
                                r_last_wb  <= i_item.write_block;
                                r_session  <= i_item.session;
                            end
                            CMD_EVENT: begin
                                if (i_item.session == SESS_STREAMING) begin
                                    r_streamed <= 1'b1;
                                    r_pending  <= 1'b0;
                                end else if (r_streamed
                                             && (i_item.session == SESS_ERROR
                                                 || i_item.session == SESS_BACKOFF
                                                 || i_item.session == SESS_RECONNECT)) begin
                                    r_pending <= 1'b1;
                                end else if (r_pending
                                             && i_item.session == SESS_CONNECTING) begin
                                    if (r_reconnects != COUNT_MAX) begin
                                        r_reconnects <= r_reconnects + 16'd1;
                                    end
                                    r_pending <= 1'b0;
                                end
                                r_session <= i_item.session;
                            end
                            CMD_CLEAR: begin
                                r_fill       <= '0;
                                r_head       <= '0;
                                r_sum        <= '0;
                                r_sq_sum     <= '0;
                                r_last_rtt   <= '0;
                                r_last_vd    <= '0;
                                r_last_wb    <= '0;
                                r_session    <= SESS_IDLE;
                                r_jitter     <= '0;
                                r_streamed   <= 1'b0;
                                r_pending    <= 1'b0;
                                r_reconnects <= '0;
                            end
                            CMD_NONE: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                EX_ACCUM: begin
                    // A full window drops its oldest entry, which sits at the head.
                    if (full) begin
                        r_sum    <= r_sum - SUM_W'(r_old_rtt) + SUM_W'(r_new_rtt);
                        r_sq_sum <= r_sq_sum - SQ_W'(r_old_sq) + SQ_W'(r_new_sq);
                    end else begin
                        r_sum    <= r_sum + SUM_W'(r_new_rtt);
                        r_sq_sum <= r_sq_sum + SQ_W'(r_new_sq);
                        r_fill   <= r_fill + NW'(1);
                    end
                    r_head <= head_nx;
                end
                EX_MUL_SQ: begin
                    if (r_fill < NW'(2)) begin
                        r_jitter <= '0;
                    end
                end
                EX_DIV: begin
                    if (last_step) begin
                        r_jitter <= quot_nx[15:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Window memory: read at the head every cycle, written once per rtt sample.
    always_ff @(posedge i_clk) begin
        r_old_rtt <= r_window[r_head];
        if (r_state == EX_ACCUM) begin
            r_window[r_head] <= r_new_rtt;
        end
    end

    // Arithmetic datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            EX_IDLE: begin
                r_new_rtt <= i_item.rtt;
                r_new_sq  <= 32'(i_item.rtt) * 32'(i_item.rtt);
            end
            EX_SQUARE_OLD: begin
                r_old_sq <= 32'(r_old_rtt) * 32'(r_old_rtt);
            end
            EX_MUL_SQ: begin
                r_prod_a <= RAD_W'(prod_fill_sq);
            end
            EX_MUL_SUM: begin
                r_prod_b <= RAD_W'(prod_sum_sum);
            end
            EX_SPREAD: begin
                r_rad  <= r_prod_a - r_prod_b;
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= CW'(ROOT_W);
            end
            EX_SQRT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_srem <= srem_nx;
                if (last_step) begin
                    r_root <= root_nx;
                    r_drem <= '0;
                    r_cnt  <= CW'(ROOT_W);
                end else begin
                    r_root <= root_nx;
                    r_cnt  <= r_cnt - CW'(1);
                end
            end
            EX_DIV: begin
                r_drem <= drem_nx;
                r_root <= quot_nx;
                r_cnt  <= r_cnt - CW'(1);
            end
            default: begin
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_level  <= grade_level(r_session, r_last_vd, r_last_wb, r_last_rtt, r_jitter);
            r_out_jitter <= r_jitter;
            r_out_count  <= r_reconnects;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_network_level   = r_out_level;
    assign o_jitter_ms       = r_out_jitter;
    assign o_reconnect_count = r_out_count;

endmodule

@@ hdl/link_quality_jitter_grader.sv @@
// Top level of the link quality jitter grader: front end, queue and executor.
// Depends on lqjg_pkg, lqjg_front, lqjg_queue and lqjg_back.
//
// Every item on the input channel (i_in_valid / o_in_ready) carries one command:
// a stats sample, a session state event, a clear, or the unused code that only
// reports. Each yields exactly one result item on the output channel
// (o_out_valid / i_out_ready): network level, jitter and reconnect count.
// Items pass a one-item input register and a two-entry queue, and the executor
// runs them one at a time. Its time per item is set by the bit-serial square
// root and divide of R steps each, R = ceil((32 + clog2(WINDOW) +
// clog2(WINDOW+1)) / 2). With fewer than two samples held the root is skipped,
// and events, clears and the unused code skip the arithmetic altogether.
// Reset clears all statistics and flags, empties the queue and drops any
// pending result; the rtt window memory is not cleared. When the receiver
// stalls, the result waits in the output register, the executor finishes its
// next item and holds it, and the queue and input register fill up before
// o_in_ready falls.
module link_quality_jitter_grader
    import lqjg_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_rtt_ms,
    input  logic [15:0] i_video_delay_ms,
    input  logic [15:0] i_write_block_ms,
    input  logic [2:0]  i_session_state,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_network_level,
    output logic [15:0] o_jitter_ms,
    output logic [15:0] o_reconnect_count
);

    logic   push;
    logic   pop;
    t_item  front_item;
    t_item  head_item;
    t_qstat qstat;

    // The front end registers and classifies each item.
    lqjg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_rtt_ms         (i_rtt_ms),
        .i_video_delay_ms (i_video_delay_ms),
        .i_write_block_ms (i_write_block_ms),
        .i_session_state  (i_session_state),
        .o_push           (push),
        .o_item           (front_item),
        .i_q_full         (qstat.full)
    );

    // The queue lets the front end keep accepting while the executor is busy.
    lqjg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (qstat)
    );

    // The executor updates the statistics and produces the result.
    lqjg_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (head_item),
        .i_q_empty         (qstat.empty),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_network_level   (o_network_level),
        .o_jitter_ms       (o_jitter_ms),
        .o_reconnect_count (o_reconnect_count)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("queue push while full");

    // The executor never takes an item from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("queue pop while empty");

    // Reset drops any pending result.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // The input channel is ready whenever the queue has room.
    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !qstat.full |-> o_in_ready)
        else $error("input stalled with room in the queue");

endmodule
